[rtl/core/psot_pkg.sv]
// ----------------------------------------------------------------------------
// psot_pkg: shared types and constants of the pending store overlap tracker
// Entry layout, command codes, controller states and the chain control bundle.
// ----------------------------------------------------------------------------
package psot_pkg;

	localparam int ADDR_W      = 64;
	localparam int LEN_W       = 13;
	localparam int DIM_W       = 8;
	localparam int ESZ_W       = 2;
	localparam int OCC_W       = 6;
	localparam int ROWLEN_W    = 11;
	// position width covers the largest supported table (256 entries and one more)
	localparam int POS_W       = 9;
	localparam int DEPTH_DEF   = 32;
	localparam int MAX_DIM_DEF = 255;

	typedef enum logic [2:0] {
		CMD_CLEAR = 3'd0,
		CMD_STORE = 3'd1,
		CMD_FENCE = 3'd2,
		CMD_CBO   = 3'd3,
		CMD_CHECK = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ROW,
		ST_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic              io;
	} entry_t;

	typedef struct packed {
		logic             pop;
		logic             wr0;
		logic [POS_W-1:0] pos0;
		entry_t           dat0;
		logic             wr1;
		logic [POS_W-1:0] pos1;
		entry_t           dat1;
	} chain_ctrl_t;

endpackage

[rtl/core/psot_cell.sv]
// ----------------------------------------------------------------------------
// psot_cell: one slot of the entry chain
// Holds one entry; on a pop takes its upper neighbour, or loads a written entry.
// ----------------------------------------------------------------------------
module psot_cell import psot_pkg::*; #(
	parameter logic [POS_W-1:0] IDX = '0
) (
	input  logic        clk,
	input  chain_ctrl_t ctrl,
	input  entry_t      nb,
	output entry_t      ent
);

	// payload only; validity is tracked by the count register of the top level
	entry_t ent_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr0 && ctrl.pos0 == IDX) begin
			ent_q <= ctrl.dat0;
		end else if (ctrl.wr1 && ctrl.pos1 == IDX) begin
			ent_q <= ctrl.dat1;
		end else if (ctrl.pop) begin
			ent_q <= nb;
		end
	end

	assign ent = ent_q;

endmodule

[rtl/core/pending_store_overlap_tracker_unit.sv]
// ----------------------------------------------------------------------------
// pending_store_overlap_tracker_unit: table of completed, unpublished stores
// Records store spans, retires them on fences and cache block operations and
// checks matrix accesses row by row against the table.
// ----------------------------------------------------------------------------
// Usage:
//  Commands arrive on the s_ group (tuser = command, tdata = operands); one
//  result transaction per command leaves on the m_ group.
//  Valid entries sit packed at the low end of a chain of cells; a count
//  register tells how many are valid. Scans pop the head cell and push the
//  surviving (or cut) entries back at the tail, one entry a cycle.
//  From the accepting edge to the result: clear, store, fence with the W
//  domain and unknown commands go straight to the done state; fence with
//  only the O domain and cbo scan every entry once; a matrix check scans
//  every entry once per row, stopping at the first hit or wrap.
//  Commands do not overlap: the controller returns to idle between them.
//  A new command is taken once the previous one is finished, even while its
//  result still waits in the output register.
//  Reset empties the table (count cleared) and drops any pending result.
//  A stalled receiver holds the result; the controller waits in its done
//  state until the output register is free.
// ----------------------------------------------------------------------------
module pending_store_overlap_tracker_unit import psot_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEF,
	parameter int MAX_DIM     = MAX_DIM_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// addr[63:0] length[76:64] io_space[77] fence_w[78] fence_o[79]
	// stride[143:80] rows[151:144] columns[159:152] elem_size_log2[161:160]
	// transpose[162], zero fill above
	input  logic [167:0] s_tdata,
	// command[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// conflict[0] conflict_row[8:1] dropped_full[9] wrap_error[10]
	// occupancy[16:11], zero fill above
	output logic [23:0]  m_tdata
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [DIM_W-1:0] DIM_CAP = (MAX_DIM > 255) ? 8'd255 : DIM_W'(MAX_DIM);

	// unpack the command transaction
	logic [ADDR_W-1:0] in_addr, in_stride;
	logic [LEN_W-1:0]  in_len;
	logic              in_io, in_fw, in_fo, in_tr;
	logic [DIM_W-1:0]  in_rows, in_cols;
	logic [ESZ_W-1:0]  in_esz;
	cmd_t              in_cmd;

	assign in_addr   = s_tdata[63:0];
	assign in_len    = s_tdata[76:64];
	assign in_io     = s_tdata[77];
	assign in_fw     = s_tdata[78];
	assign in_fo     = s_tdata[79];
	assign in_stride = s_tdata[143:80];
	assign in_rows   = s_tdata[151:144];
	assign in_cols   = s_tdata[159:152];
	assign in_esz    = s_tdata[161:160];
	assign in_tr     = s_tdata[162];
	assign in_cmd    = cmd_t'(s_tuser);

	// controller state
	state_t             state_q, state_d;
	logic [CW-1:0]      count_q, count_d, rem_q, rem_d, extra_q, extra_d, orig_q, orig_d;
	logic               fence_q, fence_d;
	logic [ADDR_W-1:0]  a_q, a_d, stride_q, stride_d, rb_q, rb_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [ROWLEN_W-1:0] rowlen_q, rowlen_d;
	logic [DIM_W-1:0]   r_q, r_d, rcount_q, rcount_d, crow_q, crow_d;
	logic               conf_q, conf_d, drop_q, drop_d, wrap_q, wrap_d;
	logic               m_tvalid_q, m_tvalid_d;
	logic [23:0]        m_tdata_q, m_tdata_d;

	// entry chain
	chain_ctrl_t ctrl;
	entry_t      ents [TABLE_DEPTH];
	entry_t      head;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			entry_t nb;
			if (gi == TABLE_DEPTH - 1) begin : g_top
				assign nb = '0;
			end else begin : g_mid
				assign nb = ents[gi+1];
			end
			psot_cell #(.IDX(POS_W'(gi))) u_cell (
				.clk    (clk),
				.ctrl   (ctrl),
				.nb     (nb),
				.ent    (ents[gi])
			);
		end
	endgenerate

	assign head = ents[0];

	// head entry arithmetic for cbo cutting
	logic [ADDR_W-1:0] d_ae, d_ea;
	logic              ea_le_a, ea_gt_a, cbo_miss, has_pre, has_suf;
	logic [LEN_W-1:0]  cbegin, clim, crest, cend;
	entry_t            pre_e, suf_e;

	always_comb begin
		d_ae    = a_q - head.addr;
		d_ea    = head.addr - a_q;
		ea_le_a = head.addr <= a_q;
		ea_gt_a = !ea_le_a;
		cbo_miss = ea_le_a ? (d_ae >= {{(ADDR_W-LEN_W){1'b0}}, head.len})
		                   : (d_ea >= {{(ADDR_W-LEN_W){1'b0}}, len_q});
		cbegin  = ea_gt_a ? '0 : d_ae[LEN_W-1:0];
		clim    = len_q - (ea_gt_a ? d_ea[LEN_W-1:0] : '0);
		crest   = head.len - cbegin;
		cend    = cbegin + ((crest < clim) ? crest : clim);
		has_pre = cbegin != '0;
		has_suf = cend < head.len;
		pre_e   = '{addr: head.addr, len: cbegin, io: 1'b0};
		suf_e   = '{addr: head.addr + {{(ADDR_W-LEN_W){1'b0}}, cend},
		            len: head.len - cend, io: 1'b0};
	end

	// head entry against the current matrix row
	logic [ADDR_W-1:0] d_er, d_re;
	logic              row_hit, row_wrap, st_wrap;
	logic [ADDR_W:0]   row_last, st_last;

	always_comb begin
		d_er     = head.addr - rb_q;
		d_re     = rb_q - head.addr;
		row_hit  = (rb_q <= head.addr)
		           ? (d_er < {{(ADDR_W-ROWLEN_W){1'b0}}, rowlen_q})
		           : (d_re < {{(ADDR_W-LEN_W){1'b0}}, head.len});
		row_last = {1'b0, rb_q} + {{(ADDR_W+1-ROWLEN_W){1'b0}}, rowlen_q - 1'b1};
		row_wrap = row_last[ADDR_W];
		st_last  = {1'b0, in_addr} + {{(ADDR_W+1-LEN_W){1'b0}}, in_len - 1'b1};
		st_wrap  = st_last[ADDR_W];
	end

	// matrix dimensions after saturation and transpose
	logic [DIM_W-1:0]    nr_s, nc_s, rc_in, cc_in;
	logic [ROWLEN_W-1:0] rowlen_in;

	always_comb begin
		nr_s      = (in_rows > DIM_CAP) ? DIM_CAP : in_rows;
		nc_s      = (in_cols > DIM_CAP) ? DIM_CAP : in_cols;
		rc_in     = in_tr ? nc_s : nr_s;
		cc_in     = in_tr ? nr_s : nc_s;
		rowlen_in = ROWLEN_W'({cc_in, 3'b000} >> (2'd3 - in_esz));
	end

	// next state and chain control
	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rem_d      = rem_q;
		extra_d    = extra_q;
		orig_d     = orig_q;
		fence_d    = fence_q;
		a_d        = a_q;
		len_d      = len_q;
		stride_d   = stride_q;
		rb_d       = rb_q;
		rowlen_d   = rowlen_q;
		r_d        = r_q;
		rcount_d   = rcount_q;
		crow_d     = crow_q;
		conf_d     = conf_q;
		drop_d     = drop_q;
		wrap_d     = wrap_q;
		m_tvalid_d = m_tready ? 1'b0 : m_tvalid_q;
		m_tdata_d  = m_tdata_q;
		s_tready   = 1'b0;
		ctrl       = '0;
		ctrl.pos0  = POS_W'(count_q) - 1'b1;
		ctrl.pos1  = POS_W'(count_q);
		ctrl.dat0  = head;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					conf_d   = 1'b0;
					crow_d   = '0;
					drop_d   = 1'b0;
					wrap_d   = 1'b0;
					a_d      = in_addr;
					len_d    = in_len;
					stride_d = in_stride;
					rb_d     = in_addr;
					rowlen_d = rowlen_in;
					rcount_d = rc_in;
					r_d      = '0;
					rem_d    = count_q;
					orig_d   = count_q;
					extra_d  = '0;
					state_d  = ST_DONE;
					case (in_cmd)
						CMD_CLEAR: count_d = '0;
						CMD_STORE: begin
							if (in_len != '0) begin
								if (st_wrap) begin
									wrap_d = 1'b1;
								end else if (count_q == DEPTH_C) begin
									drop_d = 1'b1;
								end else begin
									ctrl.wr0  = 1'b1;
									ctrl.pos0 = POS_W'(count_q);
									ctrl.dat0 = '{addr: in_addr, len: in_len, io: in_io};
									count_d   = count_q + 1'b1;
								end
							end
						end
						CMD_FENCE: begin
							fence_d = 1'b1;
							if (in_fw) begin
								count_d = '0;
							end else if (in_fo && count_q != '0) begin
								state_d = ST_SCAN;
							end
						end
						CMD_CBO: begin
							fence_d = 1'b0;
							if (in_len != '0 && count_q != '0) begin
								state_d = ST_SCAN;
							end
						end
						CMD_CHECK: begin
							if (in_rows != '0 && in_cols != '0 && count_q != '0
							    && rc_in != '0) begin
								state_d = ST_ROW;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				// pop the head, push back what survives at the tail
				ctrl.pop = 1'b1;
				rem_d    = rem_q - 1'b1;
				if (fence_q) begin
					ctrl.wr0 = !head.io;
					count_d  = count_q - (head.io ? 1'b1 : 1'b0);
				end else if (head.io || cbo_miss) begin
					ctrl.wr0 = 1'b1;
				end else if (has_pre) begin
					ctrl.wr0  = 1'b1;
					ctrl.dat0 = pre_e;
					if (has_suf) begin
						if (extra_q < DEPTH_C - orig_q) begin
							ctrl.wr1  = 1'b1;
							ctrl.dat1 = suf_e;
							extra_d   = extra_q + 1'b1;
							count_d   = count_q + 1'b1;
						end else begin
							drop_d = 1'b1;
						end
					end
				end else if (has_suf) begin
					ctrl.wr0  = 1'b1;
					ctrl.dat0 = suf_e;
				end else begin
					count_d = count_q - 1'b1;
				end
				if (rem_q == CW'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_ROW: begin
				rem_d = count_q;
				if (row_wrap) begin
					wrap_d  = 1'b1;
					state_d = ST_DONE;
				end else begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				// rotate the chain past the row span
				ctrl.pop = 1'b1;
				ctrl.wr0 = 1'b1;
				rem_d    = rem_q - 1'b1;
				if (row_hit) begin
					conf_d  = 1'b1;
					crow_d  = r_q;
					state_d = ST_DONE;
				end else if (rem_q == CW'(1)) begin
					r_d  = r_q + 1'b1;
					rb_d = rb_q + stride_q;
					state_d = (r_q + 1'b1 == rcount_q) ? ST_DONE : ST_ROW;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_tvalid_d = 1'b1;
					m_tdata_d  = {7'd0, OCC_W'(count_q), wrap_q, drop_q, crow_q, conf_q};
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q     <= rem_d;
		extra_q   <= extra_d;
		orig_q    <= orig_d;
		fence_q   <= fence_d;
		a_q       <= a_d;
		len_q     <= len_d;
		stride_q  <= stride_d;
		rb_q      <= rb_d;
		rowlen_q  <= rowlen_d;
		r_q       <= r_d;
		rcount_q  <= rcount_d;
		crow_q    <= crow_d;
		conf_q    <= conf_d;
		drop_q    <= drop_d;
		wrap_q    <= wrap_d;
		m_tdata_q <= m_tdata_d;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above table depth");
	a_scan_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_CHK) |-> rem_q != '0)
		else $error("scan with no entries left");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && in_cmd == CMD_CLEAR) |=> count_q == '0)
		else $error("clear left entries behind");
	a_rotate_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHK |=> $stable(count_q))
		else $error("matrix check changed occupancy");
`endif

endmodule

[dv/tb_pending_store_overlap_tracker_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pending_store_overlap_tracker_unit: self-checking bench of the tracker
// Drives a directed command sequence and then random commands through the
// input stream, predicts each result from a shadow copy of the store table
// and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module tb_pending_store_overlap_tracker_unit;
	import psot_pkg::*;

	localparam int DEPTH     = 32;
	localparam int DIM_LIMIT = 255;
	localparam int CYCLE_CAP = 30000000;

	typedef struct packed {
		logic [63:0] addr;
		logic [12:0] length;
		logic        io_space;
		logic        fence_w;
		logic        fence_o;
		logic [63:0] stride;
		logic [7:0]  rows;
		logic [7:0]  columns;
		logic [1:0]  elem_size_log2;
		logic        transpose;
	} operands_t;

	localparam int OPS_W = $bits(operands_t);

	typedef struct {
		cmd_t      command;
		operands_t ops;
	} command_item_t;

	// lowest field last, so conflict lands in bit 0 as on the result bus
	typedef struct packed {
		logic [5:0] occupancy;
		logic       wrap_error;
		logic       dropped_full;
		logic [7:0] conflict_row;
		logic       conflict;
	} outcome_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [167:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;

	pending_store_overlap_tracker_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// shadow table
	logic        tbl_valid [DEPTH];
	logic [63:0] tbl_addr  [DEPTH];
	logic [63:0] tbl_len   [DEPTH];
	logic        tbl_io    [DEPTH];

	command_item_t pending_cmds[$];
	outcome_t      expected_outcomes[$];
	int            mismatch_count = 0;
	int            cycle_count    = 0;
	int            results_seen   = 0;
	int            conflicts_seen = 0;
	bit            stimulus_done  = 0;
	bit            hold_off       = 0;
	bit            hold_go        = 0;
	bit            hold_done      = 0;
	bit            quiet_phase    = 0;

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at result %0d: %s got %0h want %0h", results_seen, what, got, want);
		mismatch_count++;
	endtask

	function automatic int free_slot(input logic busy [DEPTH]);
		for (int i = 0; i < DEPTH; i++)
			if (!tbl_valid[i] && !busy[i]) return i;
		return -1;
	endfunction

	function automatic int live_entries();
		int n = 0;
		for (int i = 0; i < DEPTH; i++) if (tbl_valid[i]) n++;
		return n;
	endfunction

	function automatic bit overlaps_table(input logic [63:0] start, input logic [63:0] len);
		for (int i = 0; i < DEPTH; i++) begin
			if (!tbl_valid[i]) continue;
			if (start <= tbl_addr[i] ? (tbl_addr[i] - start < len)
					: (start - tbl_addr[i] < tbl_len[i])) return 1;
		end
		return 0;
	endfunction

	// advance the shadow table by one command and work out its result
	function automatic outcome_t apply_command(input command_item_t it);
		outcome_t    o;
		operands_t   p;
		logic        orig [DEPTH];
		logic [63:0] len, ea, el, bgn, lim, rest, fin, nr, nc, rc, cc, row_len, rb;
		int          s;
		o = '0;
		p = it.ops;
		len = 64'(p.length);
		case (it.command)
			CMD_CLEAR: for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 0;
			CMD_STORE: if (len != 0) begin
				if (len - 1 > ~p.addr) o.wrap_error = 1;
				else begin
					for (int i = 0; i < DEPTH; i++) orig[i] = 0;
					s = free_slot(orig);
					if (s < 0) o.dropped_full = 1;
					else begin
						tbl_valid[s] = 1; tbl_addr[s] = p.addr;
						tbl_len[s] = len; tbl_io[s] = p.io_space;
					end
				end
			end
			CMD_FENCE: for (int i = 0; i < DEPTH; i++)
				if (tbl_valid[i] && (p.fence_w || (p.fence_o && tbl_io[i]))) tbl_valid[i] = 0;
			CMD_CBO: if (len != 0) begin
				for (int i = 0; i < DEPTH; i++) orig[i] = tbl_valid[i];
				for (int i = 0; i < DEPTH; i++) begin
					if (!orig[i] || !tbl_valid[i] || tbl_io[i]) continue;
					ea = tbl_addr[i]; el = tbl_len[i];
					if (ea <= p.addr ? (p.addr - ea >= el) : (ea - p.addr >= len)) continue;
					bgn  = p.addr > ea ? p.addr - ea : 0;
					lim  = len - (ea > p.addr ? ea - p.addr : 0);
					rest = el - bgn;
					fin  = bgn + (rest < lim ? rest : lim);
					if (bgn != 0) tbl_len[i] = bgn;
					else tbl_valid[i] = 0;
					if (fin < el) begin
						s = tbl_valid[i] ? free_slot(orig) : i;
						if (s < 0) o.dropped_full = 1;
						else begin
							tbl_valid[s] = 1; tbl_addr[s] = ea + fin;
							tbl_len[s] = el - fin; tbl_io[s] = 0;
						end
					end
				end
			end
			CMD_CHECK: if (p.rows != 0 && p.columns != 0 && live_entries() != 0) begin
				nr = p.rows > DIM_LIMIT ? DIM_LIMIT : p.rows;
				nc = p.columns > DIM_LIMIT ? DIM_LIMIT : p.columns;
				rc = p.transpose ? nc : nr;
				cc = p.transpose ? nr : nc;
				row_len = cc << p.elem_size_log2;
				for (logic [63:0] r = 0; r < rc; r++) begin
					rb = p.addr + r * p.stride;
					if (row_len - 1 > ~rb) begin
						o.wrap_error = 1;
						break;
					end
					if (overlaps_table(rb, row_len)) begin
						o.conflict = 1; o.conflict_row = r[7:0];
						break;
					end
				end
			end
			default: ;
		endcase
		o.occupancy = 6'(live_entries());
		return o;
	endfunction

	// driver: hold the offered item until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata  <= '0;
			s_tuser  <= CMD_CLEAR;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_outcomes = {expected_outcomes, apply_command(pending_cmds[0])};
				pending_cmds.delete(0);
			end
			if (!(s_tvalid && !s_tready)) begin
				if (pending_cmds.size() != 0 && (quiet_phase || $urandom_range(99) >= 29)) begin
					s_tvalid <= 1;
					s_tuser  <= pending_cmds[0].command;
					s_tdata  <= {5'd0, pending_cmds[0].ops.transpose,
						pending_cmds[0].ops.elem_size_log2, pending_cmds[0].ops.columns,
						pending_cmds[0].ops.rows, pending_cmds[0].ops.stride,
						pending_cmds[0].ops.fence_o, pending_cmds[0].ops.fence_w,
						pending_cmds[0].ops.io_space, pending_cmds[0].ops.length,
						pending_cmds[0].ops.addr};
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// monitor: compare each result transaction with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		outcome_t got, want;
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (m_tvalid && m_tready) begin
				got = m_tdata[16:0];
				results_seen++;
				if (expected_outcomes.size() == 0) begin
					report_mismatch("unexpected result", 64'(got), 64'd0);
				end else begin
					want = expected_outcomes[0];
					expected_outcomes.delete(0);
					if (want.conflict) conflicts_seen++;
					if (got.conflict != want.conflict)
						report_mismatch("conflict", 64'(got.conflict), 64'(want.conflict));
					if (got.conflict_row != want.conflict_row)
						report_mismatch("conflict_row", 64'(got.conflict_row),
							64'(want.conflict_row));
					if (got.dropped_full != want.dropped_full)
						report_mismatch("dropped_full", 64'(got.dropped_full),
							64'(want.dropped_full));
					if (got.wrap_error != want.wrap_error)
						report_mismatch("wrap_error", 64'(got.wrap_error), 64'(want.wrap_error));
					if (got.occupancy != want.occupancy)
						report_mismatch("occupancy", 64'(got.occupancy), 64'(want.occupancy));
				end
			end
			m_tready <= !hold_off && (quiet_phase || $urandom_range(99) >= 29);
		end
	end

	// receiver stall: hold off for a counted stretch once asked to
	initial begin
		wait (hold_go);
		hold_off = 1;
		repeat (300) @(posedge clk);
		hold_off = 0;
		hold_done = 1;
	end

	function automatic command_item_t make_cmd(input cmd_t c, input logic [63:0] a,
			input int len, input bit io = 0);
		command_item_t it;
		it.command = c;
		it.ops = '0;
		it.ops.addr = a;
		it.ops.length = 13'(len);
		it.ops.io_space = io;
		return it;
	endfunction

	function automatic command_item_t make_check(input logic [63:0] a, input logic [63:0] st,
			input int nr, input int nc, input int esz, input bit tr);
		command_item_t it;
		it = make_cmd(CMD_CHECK, a, 0);
		it.ops.stride = st; it.ops.rows = 8'(nr); it.ops.columns = 8'(nc);
		it.ops.elem_size_log2 = 2'(esz); it.ops.transpose = tr;
		return it;
	endfunction

	// random command mostly near a small address window so spans collide
	function automatic command_item_t random_cmd();
		command_item_t it;
		logic [63:0]   base;
		int            pick;
		pick = $urandom_range(99);
		base = ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'h1000 + $urandom_range(4095);
		it.ops = OPS_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		it.ops.addr = base;
		it.ops.length = ($urandom_range(9) == 0) ? 13'($urandom_range(4096))
			: 13'($urandom_range(64));
		if (pick < 45) it.command = CMD_STORE;
		else if (pick < 58) it.command = CMD_CBO;
		else if (pick < 66) it.command = CMD_FENCE;
		else if (pick < 68) it.command = CMD_CLEAR;
		else if (pick < 70) it.command = cmd_t'(3'($urandom_range(5, 7)));
		else begin
			it.command = CMD_CHECK;
			it.ops.rows    = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(6));
			it.ops.columns = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(8));
			if ($urandom_range(4) != 0) it.ops.stride = 64'($urandom_range(256)) - 64'd64;
		end
		if (it.command == CMD_FENCE && $urandom_range(2) != 0) it.ops.fence_w = 0;
		return it;
	endfunction

	// append one command to the driver's queue
	task automatic enqueue_cmd(input command_item_t it);
		pending_cmds = {pending_cmds, it};
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_valid[i] = 0; tbl_addr[i] = 0; tbl_len[i] = 0; tbl_io[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, wraps, fragments, fences, checks
		enqueue_cmd(make_check(64'h100, 64'h40, 4, 4, 0, 0));   // empty table
		enqueue_cmd(make_cmd(CMD_STORE, 64'h1000, 0));           // zero length
		enqueue_cmd(make_cmd(CMD_STORE, 64'h1000, 4096));
		enqueue_cmd(make_cmd(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFF0, 16, 1));
		enqueue_cmd(make_cmd(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFF1, 16)); // wraps
		enqueue_cmd(make_cmd(CMD_STORE, 64'h0, 1));
		enqueue_cmd(make_cmd(CMD_CBO, 64'h1100, 0));             // zero length
		enqueue_cmd(make_cmd(CMD_CBO, 64'h1100, 64));            // split in two
		enqueue_cmd(make_cmd(CMD_CBO, 64'hFFFF_FFFF_FFFF_FFC0, 4096)); // wrapping range
		enqueue_cmd(make_check(64'h0F00, 64'h40, 255, 8, 3, 0));
		enqueue_cmd(make_check(64'h0F00, 64'h40, 8, 255, 0, 1));
		enqueue_cmd(make_check(64'hFFFF_FFFF_FFFF_FF00, 64'h80, 4, 64, 3, 0));
		enqueue_cmd(make_check(64'h5000, 64'h10, 0, 4, 1, 0));
		enqueue_cmd(make_cmd(cmd_t'(3'd7), 64'h0, 0));
		begin
			command_item_t f;
			f = make_cmd(CMD_FENCE, 0, 0); f.ops.fence_o = 1;
			enqueue_cmd(f);
			for (int i = 0; i < 33; i++)                                  // fill, then overflow
				enqueue_cmd(make_cmd(CMD_STORE, 64'h2000 + i * 16, 8, i[0]));
			enqueue_cmd(make_cmd(CMD_CBO, 64'h2004, 8));           // cuts one entry short
			f.ops.fence_o = 0; f.ops.fence_w = 1;
			enqueue_cmd(f);
		end
		enqueue_cmd(make_cmd(CMD_CLEAR, 0, 0));

		// long stretch without idling
		quiet_phase = 1;
		for (int i = 0; i < 150; i++) enqueue_cmd(random_cmd());
		wait (pending_cmds.size() == 0);
		quiet_phase = 0;

		// receiver holds off while the sender keeps offering
		for (int i = 0; i < 50; i++) enqueue_cmd(random_cmd());
		hold_go = 1;
		wait (hold_done);

		for (int i = 0; i < 750; i++) enqueue_cmd(random_cmd());
		wait (pending_cmds.size() == 0 && !s_tvalid && expected_outcomes.size() == 0);
		repeat (20) @(posedge clk);
		stimulus_done = 1;
		$display("Covered %0d results (%0d conflicts) across clear, store, fence, cbo and checks",
			results_seen, conflicts_seen);
		if (mismatch_count == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (cycle_count >= CYCLE_CAP && !stimulus_done) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
